@@ hdl/lrubfm_pkg.sv @@
// Shared package for the LRU buffer frame manager.
// Holds the fixed field widths, parameter defaults and the controller command type.
// Depends on nothing; every other file in hdl imports it.
`timescale 1ns / 1ps

package lrubfm_pkg;

    // Port widths fixed by the request and result fields.
    localparam int PAGE_ID_W = 32;
    localparam int FRAME_W   = 4;
    localparam int CFG_W     = 5;

    // Reset value of the frame count register.
    localparam logic [CFG_W-1:0] CFG_RESET = 5'd10;

    // Defaults for the top-level parameters.
    localparam int DEF_MAX_FRAMES   = 16;
    localparam int DEF_PAGE_ID_BITS = 32;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;    // capture the requested page
        logic decide;  // search the frames and register the outcome
        logic commit;  // write back the frame table and ages
    } ctrl_cmd_t;

endpackage

@@ hdl/lru_buffer_frame_manager.sv @@
// Top level of the LRU buffer frame manager.
// Joins the controller and the datapath and checks their joint behavior.
// Depends on lrubfm_pkg, lrubfm_ctrl and lrubfm_datapath.
`timescale 1ns / 1ps

// Usage
// A page request is a transaction on the command channel: it is accepted at
// a rising edge where start is high and busy is low, and page_id is taken then.
// Exactly one result follows. It is presented on hit, frame, evicted and
// evicted_page for one cycle, marked by done, in the update after lookup.
// The receiver cannot stall; it must take the result in that cycle.
// A new request may be accepted in the same cycle that done is high, so the
// block takes a new request while the last is still in update. Busy is high
// only in the lookup cycle, where the parallel tag compare, the free-frame
// search and the oldest-age tree are evaluated; the following cycle writes
// the frame table and ages back.
// The user, not the block, must write the frame count register (cfg_wr_en,
// cfg_wr_data, no handshake) only while no request is in flight.
// Reset clears every frame to free, all ages to zero and sets the frame
// count to ten. There is no clearing pass: the block is ready at once.
module lru_buffer_frame_manager #(
    parameter int MAX_FRAMES   = lrubfm_pkg::DEF_MAX_FRAMES,
    parameter int PAGE_ID_BITS = lrubfm_pkg::DEF_PAGE_ID_BITS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [lrubfm_pkg::PAGE_ID_W-1:0] page_id,
    output logic                             done,
    output logic                             hit,
    output logic [lrubfm_pkg::FRAME_W-1:0]   frame,
    output logic                             evicted,
    output logic [lrubfm_pkg::PAGE_ID_W-1:0] evicted_page,
    input  logic                             cfg_wr_en,
    input  logic [lrubfm_pkg::CFG_W-1:0]     cfg_wr_data
);
    import lrubfm_pkg::*;

    ctrl_cmd_t cmd;

    // The controller sequences each transaction; it never looks at the data.
    lrubfm_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    // The datapath holds the frame table and performs search and update.
    lrubfm_datapath #(
        .MAX_FRAMES   (MAX_FRAMES),
        .PAGE_ID_BITS (PAGE_ID_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .page_id      (page_id),
        .hit          (hit),
        .frame        (frame),
        .evicted      (evicted),
        .evicted_page (evicted_page)
    );

    // An accepted request always moves into the lookup cycle.
    a_accept_to_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted request did not enter lookup");

    // Every result is preceded by its lookup cycle.
    a_done_after_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result without a preceding lookup");

    // An eviction only happens on a miss.
    a_evict_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
        done && evicted |-> !hit)
        else $error("eviction reported on a hit");

    // Without an eviction the evicted page reads as zero.
    a_evict_page_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && !evicted |-> evicted_page == '0)
        else $error("evicted page nonzero without eviction");

endmodule

@@ hdl/lrubfm_ctrl.sv @@
// Controller of the LRU buffer frame manager.
// Sequences each request through lookup and update and drives busy and done.
// Depends on lrubfm_pkg for the command type.
`timescale 1ns / 1ps

module lrubfm_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    output logic                  done,
    output lrubfm_pkg::ctrl_cmd_t cmd
);
    import lrubfm_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_LOOKUP = 2'd1;
    localparam logic [1:0] ST_UPDATE = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       accept;

    // A new request may enter during the update cycle of the previous one,
    // because its lookup follows the update and sees the written-back table.
    assign busy   = (state_reg == ST_LOOKUP);
    assign accept = start && !busy;
    assign done   = (state_reg == ST_UPDATE);

    assign cmd.load   = accept;
    assign cmd.decide = (state_reg == ST_LOOKUP);
    assign cmd.commit = (state_reg == ST_UPDATE);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                state_next = accept ? ST_LOOKUP : ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ hdl/lrubfm_datapath.sv @@
// Datapath of the LRU buffer frame manager.
// Holds the frame table, recency ages and frame count, searches and updates them.
// Depends on lrubfm_pkg for widths, reset values and the command type.
`timescale 1ns / 1ps

module lrubfm_datapath #(
    parameter int MAX_FRAMES   = lrubfm_pkg::DEF_MAX_FRAMES,
    parameter int PAGE_ID_BITS = lrubfm_pkg::DEF_PAGE_ID_BITS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  lrubfm_pkg::ctrl_cmd_t            cmd,
    input  logic                             cfg_wr_en,
    input  logic [lrubfm_pkg::CFG_W-1:0]     cfg_wr_data,
    input  logic [lrubfm_pkg::PAGE_ID_W-1:0] page_id,
    output logic                             hit,
    output logic [lrubfm_pkg::FRAME_W-1:0]   frame,
    output logic                             evicted,
    output logic [lrubfm_pkg::PAGE_ID_W-1:0] evicted_page
);
    import lrubfm_pkg::*;

    localparam int IDX_W   = $clog2(MAX_FRAMES);
    localparam int AGE_W   = IDX_W;
    localparam int PAGE_W  = (PAGE_ID_BITS < PAGE_ID_W) ? PAGE_ID_BITS : PAGE_ID_W;
    localparam int CNT_W   = $clog2(MAX_FRAMES + 1);
    localparam int NUM_W   = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int TREE_N  = 2 ** IDX_W;
    localparam logic [AGE_W-1:0] AGE_MAX = AGE_W'(MAX_FRAMES - 1);

    // Configuration and table state.
    logic [CFG_W-1:0]      cfg_reg;
    logic [MAX_FRAMES-1:0] used_reg;
    logic [AGE_W-1:0]      age_reg [MAX_FRAMES];
    logic [PAGE_W-1:0]     page_reg [MAX_FRAMES];

    // Request and decision registers.
    logic [PAGE_W-1:0]     req_reg;
    logic                  hit_reg;
    logic                  evicted_reg;
    logic [IDX_W-1:0]      slot_reg;
    logic [AGE_W-1:0]      hit_age_reg;
    logic [PAGE_W-1:0]     old_page_reg;

    // Search results.
    logic [NUM_W-1:0]      active_num;
    logic [MAX_FRAMES-1:0] active;
    logic [MAX_FRAMES-1:0] match;
    logic [MAX_FRAMES-1:0] free;
    logic [IDX_W-1:0]      hit_idx;
    logic [IDX_W-1:0]      free_idx;
    logic [IDX_W-1:0]      victim_idx;
    logic                  any_hit;
    logic                  any_free;
    logic [IDX_W-1:0]      slot_sel;

    logic [AGE_W-1:0]      tree_key [IDX_W+1][TREE_N];
    logic [IDX_W-1:0]      tree_idx [IDX_W+1][TREE_N];

    logic [IDX_W+FRAME_W-1:0]  frame_wide;
    logic [PAGE_W+PAGE_ID_W-1:0] evict_wide;

    // Frame count clamp: zero acts as one, values above the build size saturate.
    always_comb
    begin
        if (cfg_reg == '0)
        begin
            active_num = NUM_W'(1);
        end
        else if (NUM_W'(cfg_reg) > NUM_W'(MAX_FRAMES))
        begin
            active_num = NUM_W'(MAX_FRAMES);
        end
        else
        begin
            active_num = NUM_W'(cfg_reg);
        end
    end

    always_comb
    begin
        for (int i = 0; i < MAX_FRAMES; i++)
        begin
            active[i] = NUM_W'(i) < active_num;
            match[i]  = active[i] && used_reg[i] && (page_reg[i] == req_reg);
            free[i]   = active[i] && !used_reg[i];
        end
    end

    // Lowest-numbered matching frame and lowest-numbered free frame.
    always_comb
    begin
        hit_idx  = '0;
        free_idx = '0;
        for (int i = MAX_FRAMES - 1; i >= 0; i--)
        begin
            if (match[i])
            begin
                hit_idx = IDX_W'(i);
            end
            if (free[i])
            begin
                free_idx = IDX_W'(i);
            end
        end
    end

    assign any_hit  = |match;
    assign any_free = |free;

    // Oldest active frame by a pairwise tree. The lower index wins ties, and
    // inactive frames carry age zero, so they sit above every active frame and
    // can never be chosen.
    always_comb
    begin
        for (int l = 0; l <= IDX_W; l++)
        begin
            for (int j = 0; j < TREE_N; j++)
            begin
                tree_key[l][j] = '0;
                tree_idx[l][j] = IDX_W'(j);
            end
        end
        for (int j = 0; j < MAX_FRAMES; j++)
        begin
            tree_key[0][j] = active[j] ? age_reg[j] : '0;
        end
        for (int l = 0; l < IDX_W; l++)
        begin
            for (int j = 0; j < (TREE_N >> (l + 1)); j++)
            begin
                if (tree_key[l][2*j+1] > tree_key[l][2*j])
                begin
                    tree_key[l+1][j] = tree_key[l][2*j+1];
                    tree_idx[l+1][j] = tree_idx[l][2*j+1];
                end
                else
                begin
                    tree_key[l+1][j] = tree_key[l][2*j];
                    tree_idx[l+1][j] = tree_idx[l][2*j];
                end
            end
        end
    end

    assign victim_idx = tree_idx[IDX_W][0];

    always_comb
    begin
        priority if (any_hit)
        begin
            slot_sel = hit_idx;
        end
        else if (any_free)
        begin
            slot_sel = free_idx;
        end
        else
        begin
            slot_sel = victim_idx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (cfg_wr_en)
        begin
            cfg_reg <= cfg_wr_data;
        end
    end

    // Request capture and decision registers; these also feed the result ports.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= page_id[PAGE_W-1:0];
        end
        if (cmd.decide)
        begin
            hit_reg      <= any_hit;
            evicted_reg  <= !any_hit && !any_free;
            slot_reg     <= slot_sel;
            hit_age_reg  <= age_reg[hit_idx];
            old_page_reg <= (!any_hit && !any_free) ? page_reg[victim_idx] : '0;
        end
    end

    // Valid bits and ages. On a hit only frames younger than the hit frame
    // grow older; on a miss every other used active frame does, up to AGE_MAX.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
            for (int i = 0; i < MAX_FRAMES; i++)
            begin
                age_reg[i] <= '0;
            end
        end
        else if (cmd.commit)
        begin
            for (int i = 0; i < MAX_FRAMES; i++)
            begin
                if (IDX_W'(i) == slot_reg)
                begin
                    age_reg[i] <= '0;
                end
                else if (active[i] && used_reg[i] && (age_reg[i] < AGE_MAX) &&
                         (!hit_reg || (age_reg[i] < hit_age_reg)))
                begin
                    age_reg[i] <= age_reg[i] + AGE_W'(1);
                end
            end
            used_reg[slot_reg] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit && !hit_reg)
        begin
            page_reg[slot_reg] <= req_reg;
        end
    end

    assign frame_wide   = {FRAME_W'(0), slot_reg};
    assign evict_wide   = {PAGE_ID_W'(0), old_page_reg};
    assign hit          = hit_reg;
    assign evicted      = evicted_reg;
    assign frame        = frame_wide[FRAME_W-1:0];
    assign evicted_page = evict_wide[PAGE_ID_W-1:0];

endmodule
